// ===== src/segment_display_refresh_controller_core_assert.svh =====
// assertion helpers shared by the display refresh controller modules
// both expect signals named clk and arst_n in the module that uses them
`ifndef SEGMENT_DISPLAY_REFRESH_CONTROLLER_CORE_ASSERT_SVH
`define SEGMENT_DISPLAY_REFRESH_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define SDRC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDRC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sdrc_pkg.sv =====
`timescale 1ns / 1ps

package sdrc_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int DIG_W      = $clog2(NUM_DIGITS);
	localparam int REG_W      = 4;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_SET     = 2'd0,
		FUNC_POLL    = 2'd1,
		FUNC_EVENT   = 2'd2,
		FUNC_TIMEOUT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MON_SPEED = 2'd0,
		MON_BATT  = 2'd1,
		MON_TEMP  = 2'd2,
		MON_NONE  = 2'd3
	} monitor_t;

	typedef enum logic [1:0] {
		LINK_INIT    = 2'd0,
		LINK_ERROR   = 2'd1,
		LINK_RECOVER = 2'd2,
		LINK_OPER    = 2'd3
	} link_t;

	typedef enum logic [2:0] {
		CFG_INTENSITY = 3'd0,
		CFG_SCAN      = 3'd1,
		CFG_DECODE    = 3'd2,
		CFG_FEATURE   = 3'd3,
		CFG_REINIT    = 3'd4,
		CFG_TOGGLES   = 3'd5
	} cfg_reg_t;

	// display register indexes
	localparam logic [REG_W-1:0] REG_SHUTDOWN  = 4'd8;
	localparam logic [REG_W-1:0] REG_FEATURE   = 4'd9;
	localparam logic [REG_W-1:0] REG_INTENSITY = 4'd10;
	localparam logic [REG_W-1:0] REG_SCAN      = 4'd11;
	localparam logic [REG_W-1:0] REG_DECODE    = 4'd12;

	localparam logic [7:0] SHUTDOWN_OFF = 8'h00;
	localparam logic [7:0] SHUTDOWN_ON  = 8'h81;
	localparam logic [7:0] BLANK_CODE   = 8'h0F;
	localparam logic [7:0] DP_BIT       = 8'h80;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_SPEED = 3'd1,
		OP_BATT  = 3'd2,
		OP_TEMP  = 3'd3,
		OP_POLL  = 3'd4,
		OP_FLAG  = 3'd5
	} op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  monitor;
		logic [15:0] value;
		logic        bus_ready;
		logic        timer_done;
		logic        event_ok;
		logic        event_for_this_bus;
	} in_t;

	typedef struct packed {
		logic             write_valid;
		logic [REG_W-1:0] write_reg;
		logic [7:0]       write_data;
		logic             bus_release;
		logic             scl_valid;
		logic             scl_level;
		logic             bus_reinit;
		logic             timer_start;
		logic [1:0]       link_mode;
	} out_t;

	// classified item as it sits in the queue
	typedef struct packed {
		op_t        op;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       bus_ready;
		logic       timer_done;
		logic       flag;
	} qent_t;

endpackage

// ===== src/sdrc_front.sv =====
`timescale 1ns / 1ps

module sdrc_front (
	input  sdrc_pkg::in_t   item,
	output sdrc_pkg::qent_t ent
);
	import sdrc_pkg::*;

	localparam logic [13:0] SPEED_MAX  = 14'd9999;
	localparam logic [13:0] BATT_MAX   = 14'd1000;
	localparam logic [13:0] TEMP_MAX   = 14'd999;

	// decimal split of a value up to 9999, reciprocal multiplies
	function automatic logic [15:0] bcd_split(input logic [13:0] v);
		logic [29:0] p1;
		logic [26:0] p2;
		logic [28:0] p3;
		logic [9:0]  q1;
		logic [6:0]  q2;
		logic [3:0]  q3;
		logic [13:0] r0;
		logic [9:0]  r1;
		logic [6:0]  r2;
		p1 = 30'(v) * 30'd52429;
		p2 = 27'(v) * 27'd5243;
		p3 = 29'(v) * 29'd16778;
		q1 = p1[28:19];
		q2 = p2[25:19];
		q3 = p3[27:24];
		r0 = v - 14'(q1) * 14'd10;
		r1 = q1 - 10'(q2) * 10'd10;
		r2 = q2 - 7'(q3) * 7'd10;
		return {q3, r2[3:0], r1[3:0], r0[3:0]};
	endfunction

	logic [13:0] v_clamp;
	logic [15:0] dig;
	logic [7:0]  d0, d1, d2, d3;

	always_comb begin
		case (item.monitor)
			MON_SPEED: v_clamp = (item.value > 16'(SPEED_MAX)) ? SPEED_MAX : item.value[13:0];
			MON_BATT:  v_clamp = (item.value > 16'(BATT_MAX)) ? BATT_MAX : item.value[13:0];
			default:   v_clamp = (item.value > 16'(TEMP_MAX)) ? TEMP_MAX : item.value[13:0];
		endcase
	end

	assign dig = bcd_split(v_clamp);
	assign d0  = 8'(dig[3:0]);
	assign d1  = 8'(dig[7:4]);
	assign d2  = 8'(dig[11:8]);
	assign d3  = 8'(dig[15:12]);

	always_comb begin
		ent            = '0;
		ent.op         = OP_NONE;
		ent.bus_ready  = item.bus_ready;
		ent.timer_done = item.timer_done;
		case (item.func)
			FUNC_SET: begin
				case (item.monitor)
					MON_SPEED: begin
						ent.op = OP_SPEED;
						ent.b0 = d1;
						ent.b1 = (d3 == 8'd0 && d2 == 8'd0) ? BLANK_CODE : d2;
						ent.b2 = (d3 == 8'd0) ? BLANK_CODE : d3;
					end
					MON_BATT: begin
						ent.op = OP_BATT;
						if (v_clamp == BATT_MAX) begin
							ent.b0 = 8'd0;
							ent.b1 = 8'd0;
							ent.b2 = 8'd1;
						end else begin
							ent.b0 = d0;
							ent.b1 = d1 | DP_BIT;
							ent.b2 = (d2 == 8'd0) ? BLANK_CODE : d2;
						end
					end
					MON_TEMP: begin
						ent.op = OP_TEMP;
						ent.b0 = d1;
						ent.b1 = (d2 == 8'd0) ? BLANK_CODE : d2;
					end
					default: ent.op = OP_NONE;
				endcase
			end
			FUNC_POLL: ent.op = OP_POLL;
			FUNC_EVENT: begin
				// events for another channel leave the flag alone
				if (item.event_for_this_bus) begin
					ent.op   = OP_FLAG;
					ent.flag = !item.event_ok;
				end
			end
			FUNC_TIMEOUT: begin
				ent.op   = OP_FLAG;
				ent.flag = 1'b1;
			end
			default: ent.op = OP_NONE;
		endcase
	end

endmodule

// ===== src/sdrc_queue.sv =====
`timescale 1ns / 1ps

module sdrc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sdrc_pkg::qent_t din,
	output logic            full,
	input  logic            pop,
	output sdrc_pkg::qent_t dout,
	output logic            empty
);
	import sdrc_pkg::*;

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign dout  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`include "segment_display_refresh_controller_core_assert.svh"

	`SDRC_ASSERT_IMP(a_pop_not_empty, pop, !empty, "queue popped while empty")
	`SDRC_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + QCNT_W'(1), "queue count lost a push")

endmodule

// ===== src/sdrc_back.sv =====
`timescale 1ns / 1ps

module sdrc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            q_empty,
	input  sdrc_pkg::qent_t q_ent,
	output logic            q_pop,
	output logic            result_valid,
	input  logic            result_ready,
	output sdrc_pkg::out_t  result
);
	import sdrc_pkg::*;

	typedef enum logic [3:0] {
		MODE_INIT    = 4'b0001,
		MODE_ERROR   = 4'b0010,
		MODE_RECOVER = 4'b0100,
		MODE_OPER    = 4'b1000
	} mode_t;

	localparam logic [2:0] INIT_STEPS   = 3'd6;

	// settings
	logic [3:0]  intensity_q;
	logic [2:0]  scan_q;
	logic [7:0]  decode_q;
	logic [7:0]  feature_q;
	logic [15:0] reinit_q;
	logic [5:0]  toggles_q;

	// link state
	mode_t            mode_q, mode_d;
	logic [2:0]       step_q, step_d;
	logic [DIG_W-1:0] ptr_q, ptr_d;
	logic             err_q, err_d;
	logic [5:0]       tog_q, tog_d;
	logic [15:0]      wc_q, wc_d;
	logic [7:0]       buf_q [NUM_DIGITS];
	logic [7:0]       buf_d [NUM_DIGITS];

	out_t res_q, res_d;
	logic res_valid_q;
	logic res_scl;
	logic res_reinit;

	function automatic logic [1:0] link_code(input mode_t m);
		case (m)
			MODE_INIT:    return LINK_INIT;
			MODE_ERROR:   return LINK_ERROR;
			MODE_RECOVER: return LINK_RECOVER;
			MODE_OPER:    return LINK_OPER;
			default:      return LINK_INIT;
		endcase
	endfunction

	assign q_pop        = !q_empty && (!res_valid_q || result_ready);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign res_scl      = res_valid_q && res_q.scl_valid;
	assign res_reinit   = res_valid_q && res_q.bus_reinit;

	always_comb begin
		mode_d = mode_q;
		step_d = step_q;
		ptr_d  = ptr_q;
		err_d  = err_q;
		tog_d  = tog_q;
		wc_d   = wc_q;
		buf_d  = buf_q;
		res_d  = '0;
		case (q_ent.op)
			OP_SPEED: begin
				buf_d[6] = q_ent.b0;
				buf_d[3] = q_ent.b1;
				buf_d[0] = q_ent.b2;
			end
			OP_BATT: begin
				buf_d[7] = q_ent.b0;
				buf_d[5] = q_ent.b1;
				buf_d[1] = q_ent.b2;
			end
			OP_TEMP: begin
				buf_d[4] = q_ent.b0;
				buf_d[2] = q_ent.b1;
			end
			OP_FLAG: err_d = q_ent.flag;
			OP_POLL: begin
				case (mode_q)
					MODE_INIT: begin
						if (q_ent.bus_ready && step_q < INIT_STEPS) begin
							res_d.write_valid = 1'b1;
							step_d = step_q + 3'd1;
							case (step_q)
								3'd0: begin
									res_d.write_reg  = REG_SHUTDOWN;
									res_d.write_data = SHUTDOWN_OFF;
								end
								3'd1: begin
									res_d.write_reg  = REG_FEATURE;
									res_d.write_data = feature_q;
								end
								3'd2: begin
									res_d.write_reg  = REG_INTENSITY;
									res_d.write_data = 8'(intensity_q);
								end
								3'd3: begin
									res_d.write_reg  = REG_SCAN;
									res_d.write_data = 8'(scan_q);
								end
								3'd4: begin
									res_d.write_reg  = REG_DECODE;
									res_d.write_data = decode_q;
								end
								default: begin
									// display switched on, refresh count starts over
									res_d.write_reg  = REG_SHUTDOWN;
									res_d.write_data = SHUTDOWN_ON;
									wc_d = '0;
								end
							endcase
						end
						if (err_q) begin
							mode_d = MODE_ERROR;
						end else if (q_ent.bus_ready && step_d >= INIT_STEPS) begin
							mode_d = MODE_OPER;
						end
					end
					MODE_ERROR: begin
						res_d.bus_release = 1'b1;
						res_d.timer_start = 1'b1;
						tog_d  = '0;
						mode_d = MODE_RECOVER;
					end
					MODE_RECOVER: begin
						if (q_ent.timer_done) begin
							tog_d = tog_q + 6'd1;
							if (tog_q < toggles_q) begin
								res_d.scl_valid   = 1'b1;
								res_d.scl_level   = tog_q[0];
								res_d.timer_start = 1'b1;
							end else begin
								res_d.bus_reinit = 1'b1;
								err_d  = 1'b0;
								step_d = '0;
								ptr_d  = '0;
								mode_d = MODE_INIT;
							end
						end
					end
					MODE_OPER: begin
						if (q_ent.bus_ready) begin
							if (wc_q != 16'hFFFF) begin
								wc_d = wc_q + 16'd1;
							end
							res_d.write_valid = 1'b1;
							res_d.write_reg   = REG_W'(ptr_q);
							res_d.write_data  = buf_q[ptr_q];
							ptr_d = ptr_q + DIG_W'(1);
						end
						if (err_q) begin
							mode_d = MODE_ERROR;
						end else if (wc_d >= reinit_q) begin
							wc_d   = '0;
							err_d  = 1'b0;
							step_d = '0;
							ptr_d  = '0;
							mode_d = MODE_INIT;
						end
					end
					default: mode_d = MODE_INIT;
				endcase
			end
			default: ;
		endcase
		res_d.link_mode = link_code(mode_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q <= 4'd15;
			scan_q      <= 3'd7;
			decode_q    <= 8'd255;
			feature_q   <= 8'd2;
			reinit_q    <= 16'd500;
			toggles_q   <= 6'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INTENSITY: intensity_q <= cfg_data[3:0];
				CFG_SCAN:      scan_q      <= cfg_data[2:0];
				CFG_DECODE:    decode_q    <= cfg_data[7:0];
				CFG_FEATURE:   feature_q   <= cfg_data[7:0];
				CFG_REINIT:    reinit_q    <= cfg_data;
				CFG_TOGGLES:   toggles_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_INIT;
			step_q      <= '0;
			ptr_q       <= '0;
			err_q       <= 1'b0;
			tog_q       <= '0;
			wc_q        <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				buf_q[i] <= '0;
			end
		end else begin
			if (q_pop) begin
				mode_q      <= mode_d;
				step_q      <= step_d;
				ptr_q       <= ptr_d;
				err_q       <= err_d;
				tog_q       <= tog_d;
				wc_q        <= wc_d;
				buf_q       <= buf_d;
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_d;
		end
	end

	`include "segment_display_refresh_controller_core_assert.svh"

	`SDRC_ASSERT_IMP(a_pop_slot_free, q_pop, !res_valid_q || result_ready, "result overwritten")
	`SDRC_ASSERT_IMP(a_scl_recover, res_scl, res_q.link_mode == LINK_RECOVER, "scl outside recovery")
	`SDRC_ASSERT_IMP(a_reinit_init, res_reinit, res_q.link_mode == LINK_INIT, "reinit outside init")

endmodule

// ===== src/segment_display_refresh_controller_core.sv =====
`timescale 1ns / 1ps
// segment display refresh controller
// item channel (item_valid/item_ready/item): readings, poll steps, bus events and
// bus timeouts. result channel (result_valid/result_ready/result): exactly one
// result per item, in order, carrying the display register write, bus recovery
// controls and the link mode after the step.
// cfg_we/cfg_index/cfg_data write one of the six settings per cycle; the user must
// write them only while idle; the block does not enforce it. an accepted item is
// classified (digit split and blanking) and queued in the same cycle; the engine
// pops it once the result register is free and registers its result. one item per
// cycle is sustained while result_ready is high, set by the single engine step per
// queue entry. when result_ready is low the result register holds and the two-entry
// queue keeps accepting until it is full, then item_ready drops.
// reset clears the queue, the digit buffer and the link state (init mode) and
// loads the default settings; item_ready is high once the queue is cleared.
module segment_display_refresh_controller_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  sdrc_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_ready,
	output sdrc_pkg::out_t result,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import sdrc_pkg::*;

	qent_t front_ent;
	qent_t q_ent;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	logic  push;

	assign item_ready = !q_full;
	assign push       = item_valid && item_ready;

	sdrc_front u_front (
		.item (item),
		.ent  (front_ent)
	);

	sdrc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_ent),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_ent),
		.empty  (q_empty)
	);

	sdrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_empty      (q_empty),
		.q_ent        (q_ent),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== tb/segment_display_refresh_controller_core_test.sv =====
`timescale 1ns / 1ps

module segment_display_refresh_controller_core_test;
	import sdrc_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 250;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 225;
	localparam int INIT_WRITES  = 6;

	class display_link_checker;
		logic [3:0]  intensity;
		logic [2:0]  scan_top;
		logic [7:0]  decode_mask;
		logic [7:0]  feature_word;
		logic [15:0] reinit_after;
		logic [5:0]  recover_toggles;

		link_t       mode;
		logic [2:0]  init_step;
		logic [2:0]  digit_ptr;
		logic        error_flag;
		logic [5:0]  toggle_count;
		logic [15:0] write_count;
		logic [7:0]  digits [NUM_DIGITS];

		out_t awaited[$];
		int   failures;

		function new();
			intensity       = 4'd15;
			scan_top        = 3'd7;
			decode_mask     = 8'd255;
			feature_word    = 8'd2;
			reinit_after    = 16'd500;
			recover_toggles = 6'd20;
			mode            = LINK_INIT;
			init_step       = '0;
			digit_ptr       = '0;
			error_flag      = 1'b0;
			toggle_count    = '0;
			write_count     = '0;
			foreach (digits[k]) digits[k] = '0;
			failures        = 0;
		endfunction

		function void set_register(cfg_reg_t which, logic [15:0] v);
			case (which)
				CFG_INTENSITY: intensity       = v[3:0];
				CFG_SCAN:      scan_top        = v[2:0];
				CFG_DECODE:    decode_mask     = v[7:0];
				CFG_FEATURE:   feature_word    = v[7:0];
				CFG_REINIT:    reinit_after    = v;
				CFG_TOGGLES:   recover_toggles = v[5:0];
				default: ;
			endcase
		endfunction

		function void store_reading(logic [1:0] kind, logic [15:0] raw);
			int unsigned v;
			int unsigned d1, d2, d3, h;
			v = raw;
			case (kind)
				MON_SPEED: begin
					if (v > 9999) v = 9999;
					d1 = (v / 10) % 10;
					d2 = (v / 100) % 10;
					d3 = (v / 1000) % 10;
					digits[6] = 8'(d1);
					digits[3] = 8'(d2);
					digits[0] = 8'(d3);
					// leading zeros blanked
					if (d3 == 0) begin
						digits[0] = BLANK_CODE;
						if (d2 == 0) digits[3] = BLANK_CODE;
					end
				end
				MON_BATT: begin
					if (v > 1000) v = 1000;
					if (v == 1000) begin
						digits[7] = 8'd0;
						digits[5] = 8'd0;
						digits[1] = 8'd1;
					end else begin
						digits[7] = 8'(v % 10);
						digits[5] = 8'((v / 10) % 10) | DP_BIT;
						digits[1] = (v / 100 == 0) ? BLANK_CODE : 8'(v / 100);
					end
				end
				MON_TEMP: begin
					if (v > 999) v = 999;
					h = (v / 100) % 10;
					digits[4] = 8'((v / 10) % 10);
					digits[2] = (h == 0) ? BLANK_CODE : 8'(h);
				end
				default: ;
			endcase
		endfunction

		function out_t advance_link(in_t it);
			out_t r;
			r = '0;
			case (it.func)
				FUNC_SET:     store_reading(it.monitor, it.value);
				FUNC_EVENT:   if (it.event_for_this_bus) error_flag = !it.event_ok;
				FUNC_TIMEOUT: error_flag = 1'b1;
				default: begin
					case (mode)
						LINK_INIT: begin
							if (it.bus_ready && init_step < INIT_WRITES) begin
								r.write_valid = 1'b1;
								case (init_step)
									3'd0: begin
										r.write_reg  = REG_SHUTDOWN;
										r.write_data = SHUTDOWN_OFF;
									end
									3'd1: begin
										r.write_reg  = REG_FEATURE;
										r.write_data = feature_word;
									end
									3'd2: begin
										r.write_reg  = REG_INTENSITY;
										r.write_data = {4'd0, intensity};
									end
									3'd3: begin
										r.write_reg  = REG_SCAN;
										r.write_data = {5'd0, scan_top};
									end
									3'd4: begin
										r.write_reg  = REG_DECODE;
										r.write_data = decode_mask;
									end
									default: begin
										r.write_reg  = REG_SHUTDOWN;
										r.write_data = SHUTDOWN_ON;
										write_count  = '0;
									end
								endcase
								init_step++;
							end
							if (error_flag) mode = LINK_ERROR;
							else if (it.bus_ready && init_step >= INIT_WRITES) mode = LINK_OPER;
						end
						LINK_ERROR: begin
							r.bus_release = 1'b1;
							r.timer_start = 1'b1;
							toggle_count  = '0;
							mode          = LINK_RECOVER;
						end
						LINK_RECOVER: begin
							if (it.timer_done) begin
								if (toggle_count < recover_toggles) begin
									r.scl_valid   = 1'b1;
									r.scl_level   = toggle_count[0];
									r.timer_start = 1'b1;
									toggle_count++;
								end else begin
									toggle_count++;
									r.bus_reinit = 1'b1;
									error_flag   = 1'b0;
									init_step    = '0;
									digit_ptr    = '0;
									mode         = LINK_INIT;
								end
							end
						end
						default: begin
							if (it.bus_ready) begin
								if (write_count != 16'hFFFF) write_count++;
								r.write_valid = 1'b1;
								r.write_reg   = {1'b0, digit_ptr};
								r.write_data  = digits[digit_ptr];
								digit_ptr++;
							end
							if (error_flag) begin
								mode = LINK_ERROR;
							end else if (write_count >= reinit_after) begin
								write_count = '0;
								error_flag  = 1'b0;
								init_step   = '0;
								digit_ptr   = '0;
								mode        = LINK_INIT;
							end
						end
					endcase
				end
			endcase
			r.link_mode = mode;
			return r;
		endfunction

		function void note_item(in_t it);
			awaited.push_back(advance_link(it));
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s expected %0d got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (awaited.size() == 0) begin
				$error("result transfer with nothing outstanding");
				failures++;
				return;
			end
			want = awaited.pop_front();
			compare_field("write_valid", want.write_valid, got.write_valid);
			compare_field("write_reg", want.write_reg, got.write_reg);
			compare_field("write_data", want.write_data, got.write_data);
			compare_field("bus_release", want.bus_release, got.bus_release);
			compare_field("scl_valid", want.scl_valid, got.scl_valid);
			compare_field("scl_level", want.scl_level, got.scl_level);
			compare_field("bus_reinit", want.bus_reinit, got.bus_reinit);
			compare_field("timer_start", want.timer_start, got.timer_start);
			compare_field("link_mode", want.link_mode, got.link_mode);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	in_t         item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_t        result;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	display_link_checker keeper = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holds_asked    = 0;
	int holds_granted  = 0;
	int hold_left      = 0;
	int cycle_count    = 0;

	logic [15:0] setting [6];
	int unsigned corner_values [7] = '{0, 999, 1000, 1001, 9999, 10000, 65535};

	segment_display_refresh_controller_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when one is asked for
	always @(negedge clk) begin
		if (holds_asked != holds_granted) begin
			holds_granted = holds_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) keeper.check_result(result);
	end

	function automatic in_t make_item(func_t f, monitor_t m, logic [15:0] v, logic ready,
			logic tdone, logic ok, logic mine);
		in_t it;
		it.func               = f;
		it.monitor            = m;
		it.value              = v;
		it.bus_ready          = ready;
		it.timer_done         = tdone;
		it.event_ok           = ok;
		it.event_for_this_bus = mine;
		return it;
	endfunction

	function automatic in_t random_item();
		in_t it;
		int roll;
		it = in_t'(24'($urandom));
		roll = $urandom_range(99);
		if (roll < 22) begin
			it.func = FUNC_SET;
			case ($urandom_range(3))
				0: it.value = 16'($urandom);
				1: it.value = 16'($urandom_range(999));
				2: it.value = 16'($urandom_range(9999));
				default: it.value = 16'(corner_values[$urandom_range(6)]);
			endcase
		end else if (roll < 82) begin
			it.func       = FUNC_POLL;
			it.bus_ready  = ($urandom_range(99) < 85);
			it.timer_done = ($urandom_range(99) < 80);
		end else if (roll < 94) begin
			it.func               = FUNC_EVENT;
			it.event_for_this_bus = ($urandom_range(99) < 80);
			it.event_ok           = ($urandom_range(99) < 55);
		end else begin
			it.func = FUNC_TIMEOUT;
		end
		return it;
	endfunction

	// called and returns at a falling edge; valid stays high between back-to-back items
	task automatic offer_item(input in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		keeper.note_item(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (keeper.awaited.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_settings();
		for (int k = 0; k < 6; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(k);
			cfg_data  <= setting[k];
			keeper.set_register(cfg_reg_t'(k), setting[k]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic pick_settings(input int phase);
		case (phase)
			0: setting = '{16'd15, 16'd7, 16'd255, 16'd2, 16'd500, 16'd20};
			1: setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1};
			2: setting = '{16'd15, 16'd7, 16'd255, 16'd255, 16'd65535, 16'd62};
			default: begin
				setting[0] = 16'($urandom_range(15));
				setting[1] = 16'($urandom_range(7));
				setting[2] = 16'($urandom_range(255));
				setting[3] = 16'($urandom_range(255));
				setting[4] = 16'($urandom_range(1, 40));
				setting[5] = 16'($urandom_range(1, 12));
				// zero re-init count and zero toggle count
				if (phase == 4) begin
					setting[4] = '0;
					setting[5] = '0;
				end
			end
		endcase
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// readings at their extremes, clamping and blanking
		offer_item(make_item(FUNC_SET, MON_SPEED, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_SET, MON_SPEED, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
		offer_item(make_item(FUNC_SET, MON_SPEED, 16'd5, 1'b0, 1'b1, 1'b0, 1'b1));
		offer_item(make_item(FUNC_SET, MON_SPEED, 16'd1234, 1'b1, 1'b0, 1'b1, 1'b0));
		offer_item(make_item(FUNC_SET, MON_BATT, 16'd1000, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_SET, MON_BATT, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
		offer_item(make_item(FUNC_SET, MON_BATT, 16'd57, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_SET, MON_BATT, 16'd999, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_SET, MON_TEMP, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_SET, MON_TEMP, 16'd7, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_SET, MON_NONE, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
		// init sequence, starting with a poll while the bus is busy
		offer_item(make_item(FUNC_POLL, MON_NONE, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1));
		repeat (INIT_WRITES)
			offer_item(make_item(FUNC_POLL, MON_SPEED, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_POLL, MON_SPEED, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
		// foreign event ignored, then a failed transfer leads into recovery
		offer_item(make_item(FUNC_EVENT, MON_SPEED, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_EVENT, MON_SPEED, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
		offer_item(make_item(FUNC_POLL, MON_SPEED, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_POLL, MON_SPEED, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_POLL, MON_SPEED, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_TIMEOUT, MON_SPEED, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		offer_item(make_item(FUNC_POLL, MON_SPEED, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			pick_settings(p);
			write_settings();
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct  = 33;
					recv_stall_pct = 33;
				end
			endcase
			// long result back-pressure while items keep coming
			if (p == 0) holds_asked++;
			repeat (PHASE_ITEMS) offer_item(random_item());
			wait_drained();
		end

		if (keeper.failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
